// ----- rtl/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame pacer package
// Shared constants, controller state encoding and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int HISTORY_DEPTH_DEF   = 120;
    localparam int UPDATE_INTERVAL_DEF = 60;

    localparam int STAMP_W     = 32;
    localparam int WAIT_W      = 11;
    localparam int RATE_W      = 24;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    // floor(x / 3) == (x * THIRD_RECIP) >> THIRD_SHIFT for every x below 2^17.
    localparam int THIRD_RECIP = 43691;
    localparam int THIRD_SHIFT = 17;
    localparam int RECIP_W     = 16;

    // Rate in hundredths: 100 * 1000 ms per second, per frame interval.
    localparam int RATE_SCALE = 100000;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACE,
        ST_FETCH,
        ST_SPAN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic mem_read;
        logic pace_update;
        logic div_start;
        logic rate_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic measure_due;
        logic span_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/frame_pacer_with_rate_meter.sv -----
// ----------------------------------------------------------------------------
// Frame pacer with rate meter
// Per frame end, returns the wait that keeps an even frame pace and keeps a
// measured frame rate taken over the stamp history.
//
//  Channel  Direction  Payload
//  s_       in         tdata: now_ms[31:0], stamp_ms[63:32]
//  m_       out        tdata: wait_ms[10:0], rate_centi[34:11],
//                             rate_valid[35], rate_updated[36], zero[39:37]
//
// A frame without a rate measurement passes ST_PACE and ST_DONE on its way to
// the output register; a due measurement adds ST_FETCH and ST_SPAN and, unless
// the span is zero, ST_DIV, where the divider makes one quotient bit per cycle.
// One transaction is in work at a time; the next is taken the cycle after the
// result has gone to the output register, which holds it while m_tready is
// low. Reset clears the counters, pointers, rate and output valid; the stamp
// memory needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_pacer_with_rate_meter #(
    parameter int HISTORY_DEPTH   = fpr_pkg::HISTORY_DEPTH_DEF,
    parameter int UPDATE_INTERVAL = fpr_pkg::UPDATE_INTERVAL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpr_pkg::IN_TDATA_W-1:0]  s_tdata,  // now_ms, stamp_ms
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpr_pkg::OUT_TDATA_W-1:0] m_tdata   // wait_ms, rate_centi,
                                                      // rate_valid, rate_updated
);

    fpr_pkg::cmd_t    cmd;
    fpr_pkg::status_t status;

    fpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpr_datapath #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .UPDATE_INTERVAL (UPDATE_INTERVAL)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef SYNTHESIS
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is in work");

    a_updated_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[36] || m_tdata[35]))
        else $error("rate_updated set without rate_valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while holding a result");
`endif

endmodule

// ----- rtl/fpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame pacer controller
// Sequences one frame transaction through pacing, the optional rate
// measurement and the hand-over to the output register.
// ----------------------------------------------------------------------------
module fpr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  fpr_pkg::status_t status,
    output fpr_pkg::cmd_t    cmd
);

    fpr_pkg::state_t state_reg;
    fpr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            fpr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.mem_read  = 1'b1;
                    state_next    = fpr_pkg::ST_PACE;
                end
            end
            fpr_pkg::ST_PACE:
            begin
                cmd.pace_update = 1'b1;
                state_next = status.measure_due ? fpr_pkg::ST_FETCH : fpr_pkg::ST_DONE;
            end
            fpr_pkg::ST_FETCH:
            begin
                cmd.mem_read = 1'b1;
                state_next   = fpr_pkg::ST_SPAN;
            end
            fpr_pkg::ST_SPAN:
            begin
                if (status.span_zero)
                begin
                    state_next = fpr_pkg::ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = fpr_pkg::ST_DIV;
                end
            end
            fpr_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.rate_load = 1'b1;
                    state_next    = fpr_pkg::ST_DONE;
                end
            end
            fpr_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/fpr_divider.sv -----
// ----------------------------------------------------------------------------
// Frame pacer rate divider
// Restoring divider of a fixed numerator by a 32-bit span, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module fpr_divider #(
    parameter int NUMERATOR = fpr_pkg::RATE_SCALE * (fpr_pkg::HISTORY_DEPTH_DEF - 1),
    parameter int QUO_W     = $clog2(NUMERATOR + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fpr_pkg::STAMP_W-1:0] divisor,
    output logic                        done,
    output logic [QUO_W-1:0]            quotient
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [fpr_pkg::STAMP_W-1:0] div_reg;
    logic [fpr_pkg::STAMP_W-1:0] rem_reg;
    logic [fpr_pkg::STAMP_W-1:0] rem_next;
    logic [QUO_W-1:0]            quo_reg;
    logic [QUO_W-1:0]            quo_next;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [fpr_pkg::STAMP_W:0]   rem_shift;
    logic                        fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QUO_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_next  = fits ? fpr_pkg::STAMP_W'(rem_shift - {1'b0, div_reg})
                         : rem_shift[fpr_pkg::STAMP_W-1:0];
        quo_next  = {quo_reg[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= QUO_W'(NUMERATOR);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/fpr_datapath.sv -----
// ----------------------------------------------------------------------------
// Frame pacer datapath
// Stamp history memory, pointers and counters, wait arithmetic, rate
// divider and the output register.
// ----------------------------------------------------------------------------
module fpr_datapath #(
    parameter int HISTORY_DEPTH   = fpr_pkg::HISTORY_DEPTH_DEF,
    parameter int UPDATE_INTERVAL = fpr_pkg::UPDATE_INTERVAL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fpr_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  fpr_pkg::cmd_t                  cmd,
    output fpr_pkg::status_t               status
);

    localparam int IDX_W    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int ICNT_W   = $clog2(UPDATE_INTERVAL + 1);
    localparam int PROD_W   = CNT_W + 6;
    localparam int MUL_W    = PROD_W + fpr_pkg::RECIP_W;
    localparam int TGT_W    = $clog2(HISTORY_DEPTH * 50 / 3 + 1);
    localparam int RATE_NUM = fpr_pkg::RATE_SCALE * (HISTORY_DEPTH - 1);
    localparam int QUO_W    = $clog2(RATE_NUM + 1);
    localparam int SW       = fpr_pkg::STAMP_W;

    logic [SW-1:0]    mem [HISTORY_DEPTH];
    logic [SW-1:0]    rd_data_reg;
    logic [SW-1:0]    now_reg;
    logic [SW-1:0]    stamp_reg;
    logic [TGT_W-1:0] target_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] oldest_reg;
    logic [ICNT_W-1:0] interval_reg;
    logic [fpr_pkg::WAIT_W-1:0] wait_reg;
    logic [fpr_pkg::WAIT_W-1:0] wait_next;
    logic [fpr_pkg::RATE_W-1:0] rate_reg;
    logic [fpr_pkg::RATE_W-1:0] rate_next;
    logic             flag_reg;
    logic             upd_reg;
    logic             out_valid_reg;
    logic [fpr_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [PROD_W-1:0] pace_prod;
    logic [MUL_W-1:0]  recip_prod;
    logic [TGT_W-1:0]  target_next;
    logic [SW-1:0]     elapsed;
    logic [TGT_W-1:0]  slack;
    logic [CNT_W:0]    slot_sum;
    logic [CNT_W:0]    slot_wrap;
    logic [IDX_W-1:0]  wr_addr;
    logic              full;
    logic [ICNT_W-1:0] interval_inc;
    logic              slot_due;
    logic [SW-1:0]     span;
    logic              div_done;
    logic [QUO_W-1:0]  quotient;

    // Target pace is floor(count * 50 / 3); count * 50 is built from shifts.
    always_comb
    begin
        pace_prod   = (PROD_W'(count_reg) << 5) + (PROD_W'(count_reg) << 4)
                    + (PROD_W'(count_reg) << 1);
        recip_prod  = MUL_W'(pace_prod) * MUL_W'(fpr_pkg::THIRD_RECIP);
        target_next = TGT_W'(recip_prod >> fpr_pkg::THIRD_SHIFT);
    end

    always_comb
    begin
        elapsed = now_reg - rd_data_reg;
        slack   = target_reg;
        if (!elapsed[SW-1])
        begin
            slack = target_reg - elapsed[TGT_W-1:0];
        end
        if (count_reg == '0 || (!elapsed[SW-1] && elapsed >= SW'(target_reg)))
        begin
            wait_next = '0;
        end
        else if (32'(slack) > 32'(fpr_pkg::WAIT_MAX))
        begin
            wait_next = fpr_pkg::WAIT_MAX;
        end
        else
        begin
            wait_next = fpr_pkg::WAIT_W'(slack);
        end
    end

    always_comb
    begin
        full      = count_reg == CNT_W'(HISTORY_DEPTH);
        slot_sum  = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(count_reg);
        slot_wrap = slot_sum;
        if (slot_sum >= (CNT_W + 1)'(HISTORY_DEPTH))
        begin
            slot_wrap = slot_sum - (CNT_W + 1)'(HISTORY_DEPTH);
        end
        wr_addr      = full ? oldest_reg : IDX_W'(slot_wrap);
        interval_inc = interval_reg + 1'b1;
        slot_due     = interval_inc == ICNT_W'(UPDATE_INTERVAL);
        span         = stamp_reg - rd_data_reg;
    end

    always_comb
    begin
        if (32'(quotient) > 32'(fpr_pkg::RATE_MAX))
        begin
            rate_next = fpr_pkg::RATE_MAX;
        end
        else
        begin
            rate_next = fpr_pkg::RATE_W'(quotient);
        end
    end

    always_comb
    begin
        status.measure_due = slot_due && (count_reg >= CNT_W'(HISTORY_DEPTH - 1));
        status.span_zero   = span == '0;
        status.div_done    = div_done;
        status.out_free    = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pace_update)
        begin
            mem[wr_addr] <= stamp_reg;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[oldest_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            now_reg    <= s_tdata[SW-1:0];
            stamp_reg  <= s_tdata[2*SW-1:SW];
            target_reg <= target_next;
        end
        if (cmd.pace_update)
        begin
            wait_reg <= wait_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= fpr_pkg::OUT_TDATA_W'({upd_reg, flag_reg, rate_reg, wait_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            oldest_reg    <= '0;
            interval_reg  <= '0;
            rate_reg      <= '0;
            flag_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                upd_reg <= 1'b0;
            end
            if (cmd.pace_update)
            begin
                interval_reg <= slot_due ? '0 : interval_inc;
                if (full)
                begin
                    oldest_reg <= (oldest_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                            : oldest_reg + 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.rate_load)
            begin
                rate_reg <= rate_next;
                flag_reg <= 1'b1;
                upd_reg  <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    fpr_divider #(
        .NUMERATOR (RATE_NUM),
        .QUO_W     (QUO_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (span),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
